// File: rtl/scmd5_pkg.sv
// Package for the shader container checksum: MD5 constants, round tables and FSM state type.
// Depends on nothing; used by the round unit and the top level.
`timescale 1ns / 1ps
package scmd5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned TAIL_LIMIT = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLOCK,
    ST_FIN_BUILD,
    ST_FIN_HASH,
    ST_FIN_BUILD2,
    ST_FIN_HASH2,
    ST_OUT
  } state_t;

  // Round additive constants.
  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Rotate amount for round i.
  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index for round i.
  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
      default: g = 4'(i[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage

// File: rtl/shader_container_md5_checksum.sv
// Shader container checksum: one input item per cycle while a block fills; each full
// 64-byte block is then hashed on the shared round unit and folded into the chaining
// values, during which no item is accepted. The final byte costs one padding
// block (two when the tail is 56 bytes or more), then four result items are sent.
// A container shorter than the header gives four zero words. Synchronous reset rst
// restores the MD5 initial values and empties the counters.
`timescale 1ns / 1ps
module shader_container_md5_checksum #(
  parameter int HEADER_BYTES = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte [7:0]
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word [31:0], word_index [33:32], zeros above
  output logic        m_tlast    // last_word
);
  scmd5_pkg::state_t state, state_next;

  logic [31:0] msg [16];
  logic [31:0] dig [4];
  logic [31:0] a, b, c, d;
  logic [31:0] count;
  logic [4:0]  skip;
  logic [6:0]  round;
  logic [1:0]  out_idx;
  logic        short_run;
  logic [31:0] b_new;
  logic        hdr_done;
  logic        acc;
  logic [31:0] bits, tailword;
  logic [5:0]  tail_n;

  assign hdr_done = {27'd0, skip} >= 32'(HEADER_BYTES);
  assign acc = s_tvalid && s_tready;
  assign bits = {count[28:0], 3'd0};
  assign tailword = {2'd0, bits[31:2]} | 32'd1;
  assign tail_n = count[5:0];

  scmd5_round u_round (
    .idx(round[5:0]), .a(a), .b(b), .c(c), .d(d),
    .m(msg[scmd5_pkg::md5_g(round[5:0])]), .b_new(b_new)
  );

  // Next state.
  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    case (state)
      scmd5_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (acc) begin
          if (hdr_done && tail_n == 6'd63) state_next = scmd5_pkg::ST_BLOCK;
          else if (s_tlast) state_next = scmd5_pkg::ST_FIN_BUILD;
        end
      end
      scmd5_pkg::ST_BLOCK: if (round == 7'd64) begin
        state_next = short_run ? scmd5_pkg::ST_FIN_BUILD : scmd5_pkg::ST_IDLE;
      end
      scmd5_pkg::ST_FIN_BUILD: state_next = hdr_done ? scmd5_pkg::ST_FIN_HASH
                                                     : scmd5_pkg::ST_OUT;
      scmd5_pkg::ST_FIN_HASH: if (round == 7'd64) begin
        state_next = (tail_n >= 6'(scmd5_pkg::TAIL_LIMIT)) ? scmd5_pkg::ST_FIN_BUILD2
                                                           : scmd5_pkg::ST_OUT;
      end
      scmd5_pkg::ST_FIN_BUILD2: state_next = scmd5_pkg::ST_FIN_HASH2;
      scmd5_pkg::ST_FIN_HASH2: if (round == 7'd64) state_next = scmd5_pkg::ST_OUT;
      scmd5_pkg::ST_OUT: if (m_tready && out_idx == 2'd3) state_next = scmd5_pkg::ST_IDLE;
      default: state_next = scmd5_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= scmd5_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Counters, message words, working and chaining registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      skip <= '0;
      round <= '0;
      out_idx <= '0;
      short_run <= 1'b0;
      dig[0] <= scmd5_pkg::IV_A; dig[1] <= scmd5_pkg::IV_B;
      dig[2] <= scmd5_pkg::IV_C; dig[3] <= scmd5_pkg::IV_D;
    end else begin
      case (state)
        scmd5_pkg::ST_IDLE: if (acc) begin
          short_run <= s_tlast;
          round <= '0;
          if (!hdr_done) skip <= skip + 5'd1;
          else count <= count + 32'd1;
          a <= dig[0]; b <= dig[1]; c <= dig[2]; d <= dig[3];
          // Body bytes are packed little-endian straight into the message words.
          if (hdr_done) msg[tail_n[5:2]][{tail_n[1:0], 3'b000} +: 8] <= s_tdata;
        end
        scmd5_pkg::ST_BLOCK, scmd5_pkg::ST_FIN_HASH, scmd5_pkg::ST_FIN_HASH2: begin
          if (round == 7'd64) begin
            dig[0] <= dig[0] + a; dig[1] <= dig[1] + b;
            dig[2] <= dig[2] + c; dig[3] <= dig[3] + d;
            round <= '0;
          end else begin
            a <= d; d <= c; c <= b; b <= b_new;
            round <= round + 7'd1;
          end
        end
        scmd5_pkg::ST_FIN_BUILD: begin
          a <= dig[0]; b <= dig[1]; c <= dig[2]; d <= dig[3];
          round <= '0;
          // Padded final block built from the tail already in the message words.
          for (int p = 0; p < 64; p++) begin
            logic [7:0] v;
            v = 8'd0;
            if (tail_n >= 6'(scmd5_pkg::TAIL_LIMIT)) begin
              if (6'(p) < tail_n) v = msg[p/4][8*(p%4) +: 8];
              else if (6'(p) == tail_n) v = scmd5_pkg::PAD_BYTE;
            end else begin
              if (p < 4) v = bits[8*(p%4) +: 8];
              else if (p >= 60) v = tailword[8*(p%4) +: 8];
              else if (7'(p) < 7'(tail_n) + 7'd4) v = msg[(p-4)/4][8*(p%4) +: 8];
              else if (7'(p) == 7'(tail_n) + 7'd4) v = scmd5_pkg::PAD_BYTE;
            end
            msg[p/4][8*(p%4) +: 8] <= v;
          end
        end
        scmd5_pkg::ST_FIN_BUILD2: begin
          a <= dig[0]; b <= dig[1]; c <= dig[2]; d <= dig[3];
          round <= '0;
          for (int w = 0; w < 16; w++) begin
            msg[w] <= (w == 0) ? bits : (w == 15) ? tailword : 32'd0;
          end
        end
        scmd5_pkg::ST_OUT: if (m_tready) begin
          out_idx <= out_idx + 2'd1;
          if (out_idx == 2'd3) begin
            count <= '0;
            skip <= '0;
            dig[0] <= scmd5_pkg::IV_A; dig[1] <= scmd5_pkg::IV_B;
            dig[2] <= scmd5_pkg::IV_C; dig[3] <= scmd5_pkg::IV_D;
          end
        end
        default: ;
      endcase
    end
  end

  // Result items come from the chaining registers.
  assign m_tvalid = (state == scmd5_pkg::ST_OUT);
  assign m_tlast = (out_idx == 2'd3);
  assign m_tdata = {6'd0, out_idx, hdr_done ? dig[out_idx] : 32'd0};
endmodule

// File: rtl/scmd5_round.sv
// One MD5 round: the shared unit stepped 64 times per block by the sequencer.
// Depends on scmd5_pkg for the round tables.
`timescale 1ns / 1ps
module scmd5_round (
  input  logic [5:0]  idx,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  input  logic [31:0] m,
  output logic [31:0] b_new
);
  logic [31:0] f;
  logic [31:0] t;
  logic [4:0]  s;
  logic [63:0] rot;

  // Round function chosen by quarter.
  always_comb begin
    case (idx[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  // Sum, rotate and add.
  assign t = f + a + scmd5_pkg::md5_k(idx) + m;
  assign s = scmd5_pkg::md5_rot(idx);
  assign rot = {t, t} << s;
  assign b_new = b + rot[63:32];
endmodule

// File: tb/shader_container_md5_checksum_chk.sv
// Checker for the shader container checksum: watches both streams, predicts the
// digest words from accepted bytes and compares them with the emitted items.
// Depends on the block's port list only.
`timescale 1ns / 1ps
module shader_container_md5_checksum_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          words_pending,
  output int          containers_seen
);

  localparam int HDR_LEN = 20;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        lst;
  } digest_item_t;

  // Expected digest words, oldest first.
  digest_item_t digest_q[$];

  logic [31:0] chain [4];
  logic [7:0]  blk_bytes [64];
  logic [31:0] body_count;
  logic [4:0]  hdr_count;

  // Round constants (the MD5 sine table) and rotate amounts are written out as literal tables.
  logic [31:0] round_k [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  int rot_amt [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  task automatic new_container();
    chain[0] = 32'h67452301;
    chain[1] = 32'hEFCDAB89;
    chain[2] = 32'h98BADCFE;
    chain[3] = 32'h10325476;
    body_count = '0;
    hdr_count = '0;
  endtask

  // One MD5 compression of a 64-byte block into the chaining values.
  task automatic md5_compress(input logic [7:0] b [64]);
    logic [31:0] m [16];
    logic [31:0] a, bb, c, d, f, t;
    int g;
    for (int i = 0; i < 16; i++)
      m[i] = {b[4*i+3], b[4*i+2], b[4*i+1], b[4*i]};
    a = chain[0]; bb = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (bb & c) | (~bb & d); g = i;
      end else if (i < 32) begin
        f = (d & bb) | (~d & c); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = bb ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (bb | ~d); g = (7 * i) % 16;
      end
      t = f + a + round_k[i] + m[g];
      a = d; d = c; c = bb;
      bb = bb + ((t << rot_amt[(i / 16) * 4 + i % 4]) | (t >> (32 - rot_amt[(i / 16) * 4 + i % 4])));
    end
    chain[0] += a; chain[1] += bb; chain[2] += c; chain[3] += d;
  endtask

  // Container-specific final padding.
  task automatic close_digest();
    logic [7:0]  pad [64];
    logic [31:0] tail, bits, tailword;
    tail = body_count & 32'd63;
    bits = body_count << 3;
    tailword = (bits >> 2) | 32'd1;
    foreach (pad[i]) pad[i] = 8'h00;
    if (tail >= 56) begin
      for (int i = 0; i < tail; i++) pad[i] = blk_bytes[i];
      pad[tail] = 8'h80;
      md5_compress(pad);
      foreach (pad[i]) pad[i] = 8'h00;
    end else begin
      for (int i = 0; i < tail; i++) pad[i + 4] = blk_bytes[i];
      pad[tail + 4] = 8'h80;
    end
    {pad[3], pad[2], pad[1], pad[0]} = bits;
    {pad[63], pad[62], pad[61], pad[60]} = tailword;
    md5_compress(pad);
  endtask

  task automatic take_byte(input logic [7:0] byte_in, input logic fin);
    digest_item_t e;
    if (hdr_count < HDR_LEN) begin
      hdr_count++;
    end else begin
      blk_bytes[body_count[5:0]] = byte_in;
      body_count++;
      if (body_count[5:0] == 6'd0) md5_compress(blk_bytes);
    end
    if (fin) begin
      if (hdr_count < HDR_LEN) begin
        foreach (chain[i]) chain[i] = '0;
      end else begin
        close_digest();
      end
      for (int k = 0; k < 4; k++) begin
        e.word = chain[k];
        e.idx = 2'(k);
        e.lst = (k == 3);
        digest_q.push_back(e);
      end
      containers_seen++;
      new_container();
    end
  endtask

  assign words_pending = digest_q.size();

  // Predict on accepted bytes, compare accepted digest words.
  always @(posedge clk) begin
    digest_item_t e;
    if (rst) begin
      new_container();
      digest_q.delete();
      fail_count = 0;
      containers_seen = 0;
    end else begin
      if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", m_tdata[31:0]);
          fail_count++;
        end else begin
          e = digest_q.pop_front();
          if (m_tdata[31:0] !== e.word) begin
            $error("digest_word expected %h got %h", e.word, m_tdata[31:0]);
            fail_count++;
          end
          if (m_tdata[33:32] !== e.idx) begin
            $error("word_index expected %0d got %0d", e.idx, m_tdata[33:32]);
            fail_count++;
          end
          if (m_tdata[39:34] !== 6'd0) begin
            $error("tdata padding expected 0 got %h", m_tdata[39:34]);
            fail_count++;
          end
          if (m_tlast !== e.lst) begin
            $error("last_word expected %0d got %0d", e.lst, m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: tb/shader_container_md5_checksum_tb.sv
// Testbench top for the shader container checksum: drives containers of bytes,
// stalls the result side, and reports the verdict. Depends on the block and the checker.
`timescale 1ns / 1ps
module shader_container_md5_checksum_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          words_pending;
  int          containers_seen;
  int          bytes_sent = 0;
  bit          calm = 1'b0;
  bit          hold_sink = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  shader_container_md5_checksum uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  shader_container_md5_checksum_chk chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .words_pending(words_pending),
    .containers_seen(containers_seen)
  );

  // Offer one byte, with random idle bursts ahead of it unless the run is calm.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // A container of the given length; mode 0 random, 1 all zero, 2 all ones.
  task automatic send_container(input int len, input int mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (mode == 1) ? 8'h00 : (mode == 2) ? 8'hFF : 8'($urandom);
      send_byte(b, i == len - 1);
    end
  endtask

  // Result side: random stall bursts, one long hold when asked, none when calm.
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_sink && !held) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 9);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int len;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single-byte, short, exact header, tails around 56, extreme bytes.
    send_container(1, 2);
    send_container(19, 1);
    send_container(20, 2);
    send_container(21, 2);
    // Long receiver hold; the next containers wait, as no byte is taken while a result is held.
    hold_sink = 1'b1;
    send_container(20 + 55, 0);
    send_container(20 + 56, 2);
    send_container(20 + 64, 1);
    send_container(20 + 63, 0);

    // Random containers, mostly small, a few spanning several blocks.
    while (bytes_sent < 470) begin
      if (bytes_sent > 400) calm = 1'b1;
      case ($urandom_range(0, 5))
        0: len = $urandom_range(1, 20);
        1: len = 20 + $urandom_range(50, 70);
        2: len = 20 + $urandom_range(120, 200);
        default: len = $urandom_range(21, 50);
      endcase
      // Keep the total close to the planned byte count.
      if (len > 470 - bytes_sent) len = 470 - bytes_sent;
      send_container(len, $urandom_range(0, 9) == 0 ? 2 : 0);
    end
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;

    while (words_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d bytes in %0d containers, incl. short, empty-body and two-block tails.",
             bytes_sent, containers_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/scmd5_pkg.sv
rtl/scmd5_round.sv
rtl/shader_container_md5_checksum.sv
tb/shader_container_md5_checksum_chk.sv
tb/shader_container_md5_checksum_tb.sv
